>>> src/aitp_pkg.sv
// aitp_pkg: shared constants and types for the ascii ir timing parser
`timescale 1ns / 1ps
`default_nettype none

package aitp_pkg;

   // packet characters
   localparam logic [7:0] CharStart = 8'h24;  // '$'
   localparam logic [7:0] CharColon = 8'h3a;  // ':'
   localparam logic [7:0] CharComma = 8'h2c;  // ','
   localparam logic [7:0] CharSemi  = 8'h3b;  // ';'
   localparam logic [7:0] CharZero  = 8'h30;  // '0'
   localparam logic [7:0] CharNine  = 8'h39;  // '9'
   localparam logic [7:0] CharNul   = 8'h00;

   localparam logic [15:0] PadSpace = 16'hffff;

   // parser phases
   localparam logic [1:0] PhSeek   = 2'd0;
   localparam logic [1:0] PhFreq   = 2'd1;
   localparam logic [1:0] PhValues = 2'd2;

   // error kinds
   localparam logic [1:0] ErrNoStart  = 2'd0;
   localparam logic [1:0] ErrNoColon  = 2'd1;
   localparam logic [1:0] ErrBadValue = 2'd2;
   localparam logic [1:0] ErrTooMany  = 2'd3;

   // pair limit per packet
   localparam int CountWidth     = 7;
   localparam int PairStoreDepth = 128;
   localparam logic [CountWidth:0] PairLimit = (CountWidth + 1)'(PairStoreDepth);

   // parser state carried between items
   typedef struct packed {
      logic [1:0]            phase;
      logic [7:0]            freq_acc;
      logic [15:0]           value_acc;
      logic [15:0]           held_mark;
      logic                  mark_pending;
      logic                  after_comma;
      logic [CountWidth-1:0] pair_counter;
   } state_type;

   // one result item
   typedef struct packed {
      logic                  pair_valid;
      logic [15:0]           mark_time;
      logic [15:0]           space_time;
      logic                  frame_done;
      logic [7:0]            mod_freq_khz;
      logic [CountWidth-1:0] pair_total;
      logic                  error_flag;
      logic [1:0]            error_kind;
   } result_type;

endpackage

`default_nettype wire

>>> src/ascii_ir_timing_parser.sv
// ascii_ir_timing_parser: text packet to ir mark/space pairs, one byte per cycle while the result side does not stall
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// req       in         req_valid/req_ready  req_in_byte
// rsp       out        rsp_valid/rsp_ready  pair, frame done and error fields
//
// one byte per cycle while the result side does not stall; a byte's result passes
// through the input register, then the parse logic into the result register
// the parser state updates in the same cycle the byte leaves the input register
// a stalled result holds the input register; one more byte can wait there
// synchronous active-high reset clears the valid bits and the parser state

module ascii_ir_timing_parser (
   input  wire  logic                             clock,
   input  wire  logic                             reset,
   input  wire  logic                             req_valid,
   output logic                                   req_ready,
   input  wire  logic [7:0]                       req_in_byte,
   output logic                                   rsp_valid,
   input  wire  logic                             rsp_ready,
   output logic                                   rsp_pair_valid,
   output logic [15:0]                            rsp_mark_time,
   output logic [15:0]                            rsp_space_time,
   output logic                                   rsp_frame_done,
   output logic [7:0]                             rsp_mod_freq_khz,
   output logic [aitp_pkg::CountWidth-1:0]        rsp_pair_total,
   output logic                                   rsp_error_flag,
   output logic [1:0]                             rsp_error_kind
);
   import aitp_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_data_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type step_result;
   logic       step_has_result;
   logic       out_free;
   logic       step_fire;

   // handshake: parse when the result slot is free or being emptied
   assign out_free  = !out_valid_ff || rsp_ready;
   assign step_fire = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || step_fire;

   aitp_step u_step (
      .cur_state  (state_ff),
      .in_byte    (in_byte_ff),
      .nxt_state  (state_in),
      .result     (step_result),
      .has_result (step_has_result)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step_fire) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = step_fire && step_has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (step_fire && step_has_result) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pair_valid   = out_data_ff.pair_valid;
   assign rsp_mark_time    = out_data_ff.mark_time;
   assign rsp_space_time   = out_data_ff.space_time;
   assign rsp_frame_done   = out_data_ff.frame_done;
   assign rsp_mod_freq_khz = out_data_ff.mod_freq_khz;
   assign rsp_pair_total   = out_data_ff.pair_total;
   assign rsp_error_flag   = out_data_ff.error_flag;
   assign rsp_error_kind   = out_data_ff.error_kind;

   // an error never carries a pair or a frame done
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_flag |-> !rsp_pair_valid && !rsp_frame_done)
      else $error("error item also flags a pair or frame done");

   // every result item carries something
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pair_valid || rsp_frame_done || rsp_error_flag)
      else $error("empty result item");

   // error or frame done sends the parser back to seeking start
   assert property (@(posedge clock) disable iff (reset)
      step_fire && step_has_result && (step_result.error_flag || step_result.frame_done)
      |=> state_ff.phase == PhSeek)
      else $error("parser did not return to seeking start");

   // a new result never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> out_valid_ff && $stable(out_data_ff))
      else $error("pending result overwritten");

endmodule

`default_nettype wire

>>> src/aitp_step.sv
// aitp_step: next parser state and result for one packet byte
`timescale 1ns / 1ps
`default_nettype none

module aitp_step (
   input  wire  aitp_pkg::state_type  cur_state,
   input  wire  logic [7:0]           in_byte,
   output aitp_pkg::state_type        nxt_state,
   output aitp_pkg::result_type       result,
   output logic                       has_result
);
   import aitp_pkg::*;

   logic [CountWidth:0] cnt_inc;
   logic                at_limit;
   logic                is_digit;
   logic [7:0]          digit;
   logic [15:0]         value_x10;
   logic [7:0]          freq_x10;

   // shared arithmetic
   assign cnt_inc   = {1'b0, cur_state.pair_counter} + {{CountWidth{1'b0}}, 1'b1};
   assign at_limit  = (cnt_inc >= PairLimit);
   assign is_digit  = (in_byte >= CharZero) && (in_byte <= CharNine);
   assign digit     = in_byte - CharZero;
   assign value_x10 = (cur_state.value_acc << 3) + (cur_state.value_acc << 1);
   assign freq_x10  = (cur_state.freq_acc << 3) + (cur_state.freq_acc << 1);

   // per-phase decode
   always_comb begin
      nxt_state  = cur_state;
      result     = '0;
      has_result = 1'b0;
      unique case (cur_state.phase)
         PhFreq: begin
            priority if (in_byte == CharNul) begin
               nxt_state.phase   = PhSeek;
               result.error_flag = 1'b1;
               result.error_kind = ErrNoColon;
               has_result        = 1'b1;
            end else if (in_byte == CharColon) begin
               nxt_state.phase        = PhValues;
               nxt_state.value_acc    = '0;
               nxt_state.held_mark    = '0;
               nxt_state.mark_pending = 1'b0;
               nxt_state.after_comma  = 1'b0;
               nxt_state.pair_counter = '0;
            end else begin
               // no digit check on the frequency
               nxt_state.freq_acc = freq_x10 + in_byte - CharZero;
            end
         end
         PhValues: begin
            priority if (in_byte == CharSemi && cur_state.after_comma) begin
               has_result      = 1'b1;
               nxt_state.phase = PhSeek;
               if (cur_state.mark_pending) begin
                  nxt_state.pair_counter = cnt_inc[CountWidth-1:0];
               end
               if (cur_state.mark_pending && at_limit) begin
                  result.error_flag = 1'b1;
                  result.error_kind = ErrTooMany;
               end else begin
                  // odd value count pads the last pair
                  if (cur_state.mark_pending) begin
                     result.pair_valid = 1'b1;
                     result.mark_time  = cur_state.held_mark;
                     result.space_time = PadSpace;
                     result.pair_total = cnt_inc[CountWidth-1:0];
                  end else begin
                     result.pair_total = cur_state.pair_counter;
                  end
                  result.frame_done   = 1'b1;
                  result.mod_freq_khz = cur_state.freq_acc;
               end
            end else if (in_byte == CharComma) begin
               nxt_state.after_comma = 1'b1;
               if (!cur_state.mark_pending) begin
                  nxt_state.held_mark    = cur_state.value_acc;
                  nxt_state.mark_pending = 1'b1;
                  nxt_state.value_acc    = '0;
               end else begin
                  nxt_state.mark_pending = 1'b0;
                  nxt_state.pair_counter = cnt_inc[CountWidth-1:0];
                  has_result             = 1'b1;
                  if (at_limit) begin
                     nxt_state.phase   = PhSeek;
                     result.error_flag = 1'b1;
                     result.error_kind = ErrTooMany;
                  end else begin
                     result.pair_valid   = 1'b1;
                     result.mark_time    = cur_state.held_mark;
                     result.space_time   = cur_state.value_acc;
                     nxt_state.value_acc = '0;
                  end
               end
            end else if (!is_digit) begin
               nxt_state.phase   = PhSeek;
               result.error_flag = 1'b1;
               result.error_kind = ErrBadValue;
               has_result        = 1'b1;
            end else begin
               nxt_state.after_comma = 1'b0;
               nxt_state.value_acc   = value_x10 + {8'd0, digit};
            end
         end
         default: begin
            // seeking start, also the unused phase code
            nxt_state.phase = PhSeek;
            priority if (in_byte == CharNul) begin
               result.error_flag = 1'b1;
               result.error_kind = ErrNoStart;
               has_result        = 1'b1;
            end else if (in_byte == CharStart) begin
               nxt_state.phase    = PhFreq;
               nxt_state.freq_acc = '0;
            end else begin
               nxt_state.phase = PhSeek;
            end
         end
      endcase
   end

endmodule

`default_nettype wire
